[rtl/core/swft_pkg.sv]
// Shared types and constants of the swing-foot trajectory block.
// Channel payloads, register map codes, fixed-point angle constants, arctangent table.
// No dependencies.
package swft_pkg;

  typedef struct packed {
    logic [1:0]         leg;
    logic signed [15:0] home_x;
    logic signed [15:0] home_y;
    logic signed [15:0] foot_x;
    logic signed [15:0] foot_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
    logic [15:0]        progress;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         leg_tag;
    logic signed [15:0] next_x;
    logic signed [15:0] next_y;
    logic [14:0]        next_z;
    logic               at_touchdown;
  } out_item_t;

  // Per-item values that ride alongside the datapath.
  typedef struct packed {
    logic [1:0]         leg;
    logic signed [15:0] hx;
    logic signed [15:0] hy;
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic [14:0]        h;
    logic [26:0]        den;
    logic               done;
    logic signed [42:0] vtx;
    logic signed [42:0] vty;
  } side_t;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_STEP_PERIOD  = 3'd0;
  localparam logic [2:0] REG_LIFT_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_PHASE_TICKS  = 3'd2;
  localparam logic [2:0] REG_STANCE_TICKS = 3'd3;
  localparam logic [2:0] REG_SWING_TICKS  = 3'd4;

  localparam logic [15:0] RST_STEP_PERIOD  = 16'd655;
  localparam logic [14:0] RST_LIFT_HEIGHT  = 15'd246;
  localparam logic [9:0]  RST_PHASE_TICKS  = 10'd100;
  localparam logic [9:0]  RST_STANCE_TICKS = 10'd100;
  localparam logic [9:0]  RST_SWING_TICKS  = 10'd50;

  // Angles in Q.30 radians
  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [32:0] PI_Q30      = 33'd3373259426;
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [29:0] GAIN_Q30    = 30'd652032874;
  localparam logic [12:0] EPS_Q32     = 13'd4295;

  localparam int ATAN_LEN = 24;
  localparam logic [31:0] ATAN_Q30 [0:ATAN_LEN-1] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

endpackage

[rtl/core/swft_chan_if.sv]
// Valid/ready stream channel used for requests and results.
// Payload type is set at instantiation; no other dependencies.
interface swft_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/swing_foot_trajectory_step.sv]
// Angle reduction takes QB = 9 + max(0, 14 - FRAC_BITS) steps and the CORDIC chain
//   min(CORDIC_STEPS, 24) steps.
// Throughput: one transaction per cycle while the output is not stalled; the 36-stage
//   restoring divider and the CORDIC chain set the depth, not the rate. A skid register
//   takes one more request while a result waits at the output.
// Reset (rst_n, synchronous): clears valid bits and skid, registers to defaults.
// Uses swft_pkg and swft_chan_if.
module swing_foot_trajectory_step #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  swft_chan_if.sink   in_ch,
  swft_chan_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SH    = 14 - FRAC_BITS;
  localparam int SHL   = (SH > 0) ? SH : 0;
  localparam int SHR   = (SH < 0) ? -SH : 0;
  localparam int MAG_W = 41 + SHL;
  localparam int QB    = MAG_W - 32;
  localparam int NC    = (CORDIC_STEPS > swft_pkg::ATAN_LEN) ? swft_pkg::ATAN_LEN : CORDIC_STEPS;
  localparam int XW    = 33;
  localparam int ZW    = 35;
  localparam int RW    = 34;
  localparam int TW    = 44;
  localparam int DW    = 45;
  localparam int OW    = 45;
  localparam int R_W   = 62;
  localparam int QW    = 35;
  localparam int DQ    = QW + 1;

  typedef struct packed {
    logic [R_W-1:0]        rem;
    logic [QW-1:0]         q;
    logic                  ovf;
    logic                  dneg;
    logic signed [TW-1:0]  tx;
  } div_ax_t;

  // ---------------- configuration ----------------
  logic [15:0] step_period_r;
  logic [14:0] lift_height_r;
  logic [9:0]  phase_ticks_r, stance_ticks_r, swing_ticks_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_period_r  <= swft_pkg::RST_STEP_PERIOD;
      lift_height_r  <= swft_pkg::RST_LIFT_HEIGHT;
      phase_ticks_r  <= swft_pkg::RST_PHASE_TICKS;
      stance_ticks_r <= swft_pkg::RST_STANCE_TICKS;
      swing_ticks_r  <= swft_pkg::RST_SWING_TICKS;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        swft_pkg::REG_STEP_PERIOD:  step_period_r  <= pwdata[15:0];
        swft_pkg::REG_LIFT_HEIGHT:  lift_height_r  <= pwdata[14:0];
        swft_pkg::REG_PHASE_TICKS:  phase_ticks_r  <= pwdata[9:0];
        swft_pkg::REG_STANCE_TICKS: stance_ticks_r <= pwdata[9:0];
        swft_pkg::REG_SWING_TICKS:  swing_ticks_r  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      swft_pkg::REG_STEP_PERIOD:  prdata = {16'd0, step_period_r};
      swft_pkg::REG_LIFT_HEIGHT:  prdata = {17'd0, lift_height_r};
      swft_pkg::REG_PHASE_TICKS:  prdata = {22'd0, phase_ticks_r};
      swft_pkg::REG_STANCE_TICKS: prdata = {22'd0, stance_ticks_r};
      swft_pkg::REG_SWING_TICKS:  prdata = {22'd0, swing_ticks_r};
      default:                    prdata = 32'd0;
    endcase
  end

  // ---------------- input skid and pipeline enable ----------------
  logic                 en;
  logic                 out_valid_r;
  swft_pkg::out_item_t  out_r;
  logic                 skid_v_r;
  swft_pkg::in_item_t   skid_r;
  logic                 in_acc;
  swft_pkg::in_item_t   s0_item;
  logic                 s0_v;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !skid_v_r;
  assign in_acc      = in_ch.valid && !skid_v_r;
  assign s0_item     = skid_v_r ? skid_r : in_ch.data;
  assign s0_v        = skid_v_r || in_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) skid_v_r <= 1'b0;
    else if (en) skid_v_r <= 1'b0;
    else if (in_acc) skid_v_r <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!en && in_acc) skid_r <= in_ch.data;
  end

  // ---------------- S1: config products, height ----------------
  logic [16:0] s0_rem, s0_hsel;
  logic [32:0] s0_hprod;
  swft_pkg::side_t s0_side;

  assign s0_rem   = 17'h10000 - {1'b0, s0_item.progress};
  assign s0_hsel  = s0_item.progress[15] ? s0_rem : {1'b0, s0_item.progress};
  assign s0_hprod = 33'(lift_height_r * s0_hsel) + 33'd16384;

  always_comb begin
    s0_side      = '0;
    s0_side.leg  = s0_item.leg;
    s0_side.hx   = s0_item.home_x;
    s0_side.hy   = s0_item.home_y;
    s0_side.fx   = s0_item.foot_x;
    s0_side.fy   = s0_item.foot_y;
    s0_side.h    = s0_hprod[29:15];
    s0_side.den  = 27'(s0_rem * swing_ticks_r);
  end

  logic               s1_v_r;
  swft_pkg::side_t    s1_side_r;
  logic signed [15:0] s1_vx_r, s1_vy_r, s1_yaw_r;
  logic [16:0]        s1_rem_r;
  logic [25:0]        s1_ps_r, s1_pt_r, s1_ts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= s0_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= s0_side;
      s1_vx_r   <= s0_item.vel_x;
      s1_vy_r   <= s0_item.vel_y;
      s1_yaw_r  <= s0_item.yaw_rate;
      s1_rem_r  <= s0_rem;
      s1_ps_r   <= 26'(stance_ticks_r * step_period_r);
      s1_pt_r   <= 26'(phase_ticks_r * step_period_r);
      s1_ts_r   <= 26'(swing_ticks_r * step_period_r);
    end
  end

  // ---------------- S2: raw angle, displacement, remaining time ----------------
  logic signed [42:0] s1_raw, s1_vtx, s1_vty;
  logic [42:0]        s1_left;
  swft_pkg::side_t    s1_side_x;

  assign s1_raw  = $signed({1'b0, s1_ps_r}) * s1_yaw_r;
  assign s1_vtx  = $signed({1'b0, s1_pt_r}) * s1_vx_r;
  assign s1_vty  = $signed({1'b0, s1_pt_r}) * s1_vy_r;
  assign s1_left = s1_ts_r * s1_rem_r;

  always_comb begin
    s1_side_x      = s1_side_r;
    s1_side_x.vtx  = s1_vtx;
    s1_side_x.vty  = s1_vty;
    s1_side_x.done = (s1_left < 43'(swft_pkg::EPS_Q32));
  end

  logic               s2_v_r;
  swft_pkg::side_t    s2_side_r;
  logic signed [41:0] s2_raw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side_r <= s1_side_x;
      s2_raw_r  <= s1_raw[41:0];
    end
  end

  // ---------------- angle magnitude and modulo 2*pi ----------------
  logic [41:0] s2_abs;
  assign s2_abs = s2_raw_r[41] ? 42'(-s2_raw_r) : 42'(s2_raw_r);

  logic             md_v_r   [0:QB];
  logic             md_neg_r [0:QB];
  logic [MAG_W-1:0] md_m_r   [0:QB];
  swft_pkg::side_t  md_side_r[0:QB];

  always_ff @(posedge clk) begin
    if (!rst_n) md_v_r[0] <= 1'b0;
    else if (en) md_v_r[0] <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_neg_r[0]  <= s2_raw_r[41];
      md_m_r[0]    <= (MAG_W'(s2_abs[40:0]) << SHL) >> SHR;
      md_side_r[0] <= s2_side_r;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_mod
    localparam logic [MAG_W-1:0] SUB = MAG_W'(swft_pkg::TWO_PI_Q30) << (QB - k);

    always_ff @(posedge clk) begin
      if (!rst_n) md_v_r[k] <= 1'b0;
      else if (en) md_v_r[k] <= md_v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        md_m_r[k]    <= (md_m_r[k-1] >= SUB) ? md_m_r[k-1] - SUB : md_m_r[k-1];
        md_neg_r[k]  <= md_neg_r[k-1];
        md_side_r[k] <= md_side_r[k-1];
      end
    end
  end

  // ---------------- wrap to (-pi, pi], apply sign ----------------
  localparam logic signed [ZW-1:0] PI_Z   = ZW'(swft_pkg::PI_Q30);
  localparam logic signed [ZW-1:0] TPI_Z  = ZW'(swft_pkg::TWO_PI_Q30);
  localparam logic signed [ZW-1:0] HPI_Z  = ZW'(swft_pkg::HALF_PI_Q30);

  logic signed [ZW-1:0] fa_w;
  always_comb begin
    fa_w = $signed(ZW'(md_m_r[QB][32:0]));
    if (fa_w > PI_Z) fa_w = fa_w - TPI_Z;
    if (md_neg_r[QB]) fa_w = -fa_w;
  end

  logic                 fa_v_r;
  logic signed [ZW-1:0] fa_z_r;
  swft_pkg::side_t      fa_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) fa_v_r <= 1'b0;
    else if (en) fa_v_r <= md_v_r[QB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fa_z_r    <= fa_w;
      fa_side_r <= md_side_r[QB];
    end
  end

  // ---------------- fold into [-pi/2, pi/2], CORDIC ----------------
  logic                 cv_r   [0:NC];
  logic                 cf_r   [0:NC];
  logic signed [XW-1:0] cx_r   [0:NC];
  logic signed [XW-1:0] cy_r   [0:NC];
  logic signed [ZW-1:0] cz_r   [0:NC];
  swft_pkg::side_t      cs_r   [0:NC];

  logic signed [ZW-1:0] fb_z;
  logic                 fb_flip;
  always_comb begin
    fb_z    = fa_z_r;
    fb_flip = 1'b0;
    if (fa_z_r > HPI_Z) begin
      fb_z    = fa_z_r - PI_Z;
      fb_flip = 1'b1;
    end else if (fa_z_r < -HPI_Z) begin
      fb_z    = fa_z_r + PI_Z;
      fb_flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else if (en) cv_r[0] <= fa_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cf_r[0] <= fb_flip;
      cz_r[0] <= fb_z;
      cx_r[0] <= XW'(fa_side_r.hx) <<< 14;
      cy_r[0] <= XW'(fa_side_r.hy) <<< 14;
      cs_r[0] <= fa_side_r;
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] ATAN = ZW'(swft_pkg::ATAN_Q30[i]);
    logic signed [XW-1:0] xs, ys;

    assign xs = cx_r[i] >>> i;
    assign ys = cy_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i+1] <= 1'b0;
      else if (en) cv_r[i+1] <= cv_r[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cf_r[i+1] <= cf_r[i];
        cs_r[i+1] <= cs_r[i];
        if (!cz_r[i][ZW-1]) begin
          cx_r[i+1] <= cx_r[i] - ys;
          cy_r[i+1] <= cy_r[i] + xs;
          cz_r[i+1] <= cz_r[i] - ATAN;
        end else begin
          cx_r[i+1] <= cx_r[i] + ys;
          cy_r[i+1] <= cy_r[i] - xs;
          cz_r[i+1] <= cz_r[i] + ATAN;
        end
      end
    end
  end

  // ---------------- gain, touchdown point, offset ----------------
  logic                 g1_v_r, g2_v_r, g3_v_r, g4_v_r;
  logic                 g1_f_r, g2_f_r;
  swft_pkg::side_t      g1_side_r, g2_side_r, g3_side_r, g4_side_r;
  logic signed [63:0]   g1_p_r  [0:1];
  logic signed [RW-1:0] g2_r_r  [0:1];
  logic signed [TW-1:0] g3_tx_r [0:1];
  logic signed [TW-1:0] g4_tx_r [0:1];
  logic signed [DW-1:0] g4_d_r  [0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_v_r <= 1'b0;
      g2_v_r <= 1'b0;
      g3_v_r <= 1'b0;
      g4_v_r <= 1'b0;
    end else if (en) begin
      g1_v_r <= cv_r[NC];
      g2_v_r <= g1_v_r;
      g3_v_r <= g2_v_r;
      g4_v_r <= g3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_side_r <= cs_r[NC];
      g1_f_r    <= cf_r[NC];
      g1_p_r[0] <= cx_r[NC] * $signed({1'b0, swft_pkg::GAIN_Q30});
      g1_p_r[1] <= cy_r[NC] * $signed({1'b0, swft_pkg::GAIN_Q30});
      g2_side_r <= g1_side_r;
      g2_f_r    <= g1_f_r;
      g3_side_r <= g2_side_r;
      g4_side_r <= g3_side_r;
      for (int a = 0; a < 2; a++) begin
        g2_r_r[a] <= RW'((g1_p_r[a] + 64'sd134217728) >>> 28);
      end
      g3_tx_r[0] <= g2_f_r ? TW'(g2_side_r.vtx) - TW'(g2_r_r[0])
                           : TW'(g2_side_r.vtx) + TW'(g2_r_r[0]);
      g3_tx_r[1] <= g2_f_r ? TW'(g2_side_r.vty) - TW'(g2_r_r[1])
                           : TW'(g2_side_r.vty) + TW'(g2_r_r[1]);
      g4_tx_r[0] <= g3_tx_r[0];
      g4_tx_r[1] <= g3_tx_r[1];
      g4_d_r[0]  <= DW'(g3_tx_r[0]) - (DW'(g3_side_r.fx) <<< 16);
      g4_d_r[1]  <= DW'(g3_tx_r[1]) - (DW'(g3_side_r.fy) <<< 16);
    end
  end

  // ---------------- restoring divider, overflow check then one quotient bit per stage ----------------
  logic            dv_v_r    [0:DQ];
  swft_pkg::side_t dv_side_r [0:DQ];
  div_ax_t         dv_r      [0:DQ][0:1];

  div_ax_t     g4_ax [0:1];
  logic [43:0] g4_m  [0:1];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      g4_m[a]       = g4_d_r[a][DW-1] ? 44'(-g4_d_r[a]) : 44'(g4_d_r[a]);
      g4_ax[a]      = '0;
      g4_ax[a].dneg = g4_d_r[a][DW-1];
      g4_ax[a].tx   = g4_tx_r[a];
      g4_ax[a].rem  = R_W'({g4_m[a], 16'd0}) + R_W'(g4_side_r.den[26:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (en) dv_v_r[0] <= g4_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side_r[0] <= g4_side_r;
      dv_r[0][0]   <= g4_ax[0];
      dv_r[0][1]   <= g4_ax[1];
    end
  end

  for (genvar k = 1; k <= DQ; k++) begin : g_div
    localparam int S = DQ - k;
    logic [R_W-1:0] dvs;
    div_ax_t        dnx [0:1];

    assign dvs = R_W'(dv_side_r[k-1].den) << S;

    if (k == 1) begin : g_ovf
      // quotient would not fit: result saturates
      always_comb begin
        for (int a = 0; a < 2; a++) begin
          dnx[a]     = dv_r[k-1][a];
          dnx[a].ovf = (dv_r[k-1][a].rem >= dvs);
        end
      end
    end else begin : g_bit
      always_comb begin
        for (int a = 0; a < 2; a++) begin
          dnx[a] = dv_r[k-1][a];
          if (dv_r[k-1][a].rem >= dvs) begin
            dnx[a].rem  = dv_r[k-1][a].rem - dvs;
            dnx[a].q[S] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k] <= 1'b0;
      else if (en) dv_v_r[k] <= dv_v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_side_r[k] <= dv_side_r[k-1];
        dv_r[k][0]   <= dnx[0];
        dv_r[k][1]   <= dnx[1];
      end
    end
  end

  // ---------------- final position, rounding, saturation ----------------
  localparam logic signed [OW-1:0] BIG = OW'(64'sd1099511627776);

  logic signed [OW-1:0] f0_o [0:1];
  logic signed [OW-1:0] f0_wf, f0_q;
  always_comb begin
    f0_wf = '0;
    f0_q  = '0;
    for (int a = 0; a < 2; a++) begin
      f0_wf = (a == 0) ? (OW'(dv_side_r[DQ].fx) <<< 16) : (OW'(dv_side_r[DQ].fy) <<< 16);
      f0_q  = $signed(OW'(dv_r[DQ][a].q));
      if (dv_side_r[DQ].done) f0_o[a] = OW'(dv_r[DQ][a].tx);
      else if (dv_r[DQ][a].ovf) f0_o[a] = dv_r[DQ][a].dneg ? -BIG : BIG;
      else f0_o[a] = dv_r[DQ][a].dneg ? f0_wf - f0_q : f0_wf + f0_q;
    end
  end

  logic                 f1_v_r;
  swft_pkg::side_t      f1_side_r;
  logic signed [OW-1:0] f1_o_r [0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) f1_v_r <= 1'b0;
    else if (en) f1_v_r <= dv_v_r[DQ];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_side_r <= dv_side_r[DQ];
      f1_o_r[0] <= f0_o[0];
      f1_o_r[1] <= f0_o[1];
    end
  end

  logic signed [OW-17:0] f1_rs [0:1];
  logic signed [15:0]    f1_sat [0:1];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      f1_rs[a] = (OW-16)'((f1_o_r[a] + 45'sd32768) >>> 16);
      if (f1_rs[a] > 29'sd32767) f1_sat[a] = 16'sh7FFF;
      else if (f1_rs[a] < -29'sd32768) f1_sat[a] = 16'sh8000;
      else f1_sat[a] = f1_rs[a][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= f1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.leg_tag      <= f1_side_r.leg;
      out_r.next_x       <= f1_sat[0];
      out_r.next_y       <= f1_sat[1];
      out_r.next_z       <= f1_side_r.h;
      out_r.at_touchdown <= f1_side_r.done;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

`ifndef SYNTHESIS
  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(!en))
    else $error("skid register filled while pipeline was advancing");

  a_mod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    md_v_r[QB] |-> (md_m_r[QB] < MAG_W'(swft_pkg::TWO_PI_Q30)))
    else $error("angle not reduced below 2*pi");

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    cv_r[0] |-> (cz_r[0] <= HPI_Z && cz_r[0] >= -HPI_Z))
    else $error("CORDIC start angle outside [-pi/2, pi/2]");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_v_r[0] && !dv_side_r[0].done) |-> (dv_side_r[0].den != 27'd0))
    else $error("divider entered with zero divisor");
`endif

endmodule

[sim/swing_foot_trajectory_step_tb.sv]
// Testbench for swing_foot_trajectory_step: directed and random requests under several
// register settings, checked against an in-bench fixed-point predictor.
// Depends on swft_pkg, swft_chan_if and the block itself.
module swing_foot_trajectory_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_N   = 16;
  localparam int DRAIN_WAIT = 120;
  localparam int CYCLE_CAP  = 600000;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  swft_chan_if #(.payload_t(swft_pkg::in_item_t)) in_if ();
  swft_chan_if #(.payload_t(swft_pkg::out_item_t)) out_if ();

  swing_foot_trajectory_step uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of the registers
  logic [15:0] cur_period;
  logic [14:0] cur_lift;
  logic [9:0]  cur_phase, cur_stance, cur_swing;

  swft_pkg::out_item_t pending_steps[$];
  int errors;
  int cycles;
  int stall_left;
  bit sink_free;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("swing_foot_trajectory_step_tb: errors");
        $finish;
      end
    end
  end

  function automatic longint rshift_round(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic swft_pkg::out_item_t foot_step(swft_pkg::in_item_t it);
    swft_pkg::out_item_t o;
    longint t, raw, mag, r, x, y, z, xs, ys, rx, ry, tx, ty;
    longint rem, left, den, wfx, wfy, d, m, v, ox, oy, h;
    bit neg, flip, done;
    t = longint'(cur_period);
    raw = longint'(cur_stance) * t * longint'(it.yaw_rate);
    neg = raw < 0;
    mag = neg ? -raw : raw;
    mag = mag <<< 2;  // Q.28 to Q.30
    r = mag % longint'(swft_pkg::TWO_PI_Q30);
    if (r > longint'(swft_pkg::PI_Q30)) r -= longint'(swft_pkg::TWO_PI_Q30);
    if (neg) r = -r;
    flip = 0;
    if (r > longint'(swft_pkg::HALF_PI_Q30)) begin
      r -= longint'(swft_pkg::PI_Q30);
      flip = 1;
    end else if (r < -longint'(swft_pkg::HALF_PI_Q30)) begin
      r += longint'(swft_pkg::PI_Q30);
      flip = 1;
    end
    x = longint'(it.home_x) * 16384;
    y = longint'(it.home_y) * 16384;
    z = r;
    for (int i = 0; i < CORDIC_N; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(swft_pkg::ATAN_Q30[i]);
      end else begin
        x += ys; y -= xs; z += longint'(swft_pkg::ATAN_Q30[i]);
      end
    end
    rx = rshift_round(x * longint'(swft_pkg::GAIN_Q30), 28);
    ry = rshift_round(y * longint'(swft_pkg::GAIN_Q30), 28);
    if (flip) begin
      rx = -rx;
      ry = -ry;
    end
    tx = rx + longint'(it.vel_x) * longint'(cur_phase) * t;
    ty = ry + longint'(it.vel_y) * longint'(cur_phase) * t;
    rem = 65536 - longint'(it.progress);
    left = t * longint'(cur_swing) * rem;
    done = left < longint'(swft_pkg::EPS_Q32);
    ox = tx;
    oy = ty;
    if (!done) begin
      den = longint'(cur_swing) * rem;
      wfx = longint'(it.foot_x) * 65536;
      wfy = longint'(it.foot_y) * 65536;
      d = tx - wfx;
      m = d < 0 ? -d : d;
      v = (m * 65536 + den / 2) / den;
      ox = wfx + (d < 0 ? -v : v);
      d = ty - wfy;
      m = d < 0 ? -d : d;
      v = (m * 65536 + den / 2) / den;
      oy = wfy + (d < 0 ? -v : v);
    end
    if (it.progress < 16'd32768)
      h = (longint'(cur_lift) * longint'(it.progress) + 16384) >> 15;
    else
      h = (longint'(cur_lift) * rem + 16384) >> 15;
    o.leg_tag = it.leg;
    o.next_x = clamp16(rshift_round(ox, 16));
    o.next_y = clamp16(rshift_round(oy, 16));
    o.next_z = h[14:0];
    o.at_touchdown = done;
    return o;
  endfunction

  // result checker
  always @(posedge clk) begin
    swft_pkg::out_item_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_steps.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = pending_steps.pop_front();
        if (got.leg_tag !== want.leg_tag) begin
          $display("%0t: leg_tag exp %0d got %0d", $time, want.leg_tag, got.leg_tag);
          errors++;
        end
        if (got.next_x !== want.next_x) begin
          $display("%0t: next_x exp %0d got %0d", $time, want.next_x, got.next_x);
          errors++;
        end
        if (got.next_y !== want.next_y) begin
          $display("%0t: next_y exp %0d got %0d", $time, want.next_y, got.next_y);
          errors++;
        end
        if (got.next_z !== want.next_z) begin
          $display("%0t: next_z exp %0d got %0d", $time, want.next_z, got.next_z);
          errors++;
        end
        if (got.at_touchdown !== want.at_touchdown) begin
          $display("%0t: at_touchdown exp %0b got %0b", $time, want.at_touchdown,
                   got.at_touchdown);
          errors++;
        end
      end
    end
  end

  // result-side backpressure
  initial begin
    out_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !sink_free) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        int roll;
        out_if.ready = 1'b1;
        stall_left = 0;
        roll = $urandom_range(0, 99);
        if (roll < 10) stall_left = $urandom_range(1, 3);
        else if (roll < 12) stall_left = $urandom_range(10, 40);
      end
    end
  end

  task automatic send_request(swft_pkg::in_item_t it, int gap);
    @(negedge clk);
    in_if.data = it;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    pending_steps.push_back(foot_step(it));
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic int pick_gap(bit busy);
    int roll;
    if (busy) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      swft_pkg::REG_STEP_PERIOD:  cur_period = val[15:0];
      swft_pkg::REG_LIFT_HEIGHT:  cur_lift   = val[14:0];
      swft_pkg::REG_PHASE_TICKS:  cur_phase  = val[9:0];
      swft_pkg::REG_STANCE_TICKS: cur_stance = val[9:0];
      swft_pkg::REG_SWING_TICKS:  cur_swing  = val[9:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    wait (pending_steps.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_regs(logic [15:0] per, logic [14:0] lift, logic [9:0] ph,
                          logic [9:0] st, logic [9:0] sw);
    drain();
    write_reg(swft_pkg::REG_STEP_PERIOD, per);
    write_reg(swft_pkg::REG_LIFT_HEIGHT, lift);
    write_reg(swft_pkg::REG_PHASE_TICKS, ph);
    write_reg(swft_pkg::REG_STANCE_TICKS, st);
    write_reg(swft_pkg::REG_SWING_TICKS, sw);
  endtask

  function automatic logic [15:0] pick_progress();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 40));
      1: return 16'($urandom_range(32760, 32775));
      2: return 16'($urandom_range(65500, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_pos();
    // mostly body-sized coordinates, sometimes the full range
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 2400)) - 1200);
  endfunction

  function automatic swft_pkg::in_item_t random_request();
    swft_pkg::in_item_t it;
    it.leg = 2'($urandom);
    it.home_x = pick_pos();
    it.home_y = pick_pos();
    it.foot_x = pick_pos();
    it.foot_y = pick_pos();
    it.vel_x = pick_pos();
    it.vel_y = pick_pos();
    it.yaw_rate = ($urandom_range(0, 2) == 0) ? 16'($urandom) : pick_pos();
    it.progress = pick_progress();
    return it;
  endfunction

  task automatic test_extremes();
    swft_pkg::in_item_t it;
    logic [15:0] edges[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    for (int i = 0; i < 4; i++) begin
      it.leg = 2'(i);
      it.home_x = edges[i]; it.home_y = edges[(i + 1) % 4];
      it.foot_x = edges[(i + 2) % 4]; it.foot_y = edges[(i + 3) % 4];
      it.vel_x = edges[i]; it.vel_y = edges[(i + 3) % 4];
      it.yaw_rate = edges[(i + 1) % 4];
      it.progress = edges[i];
      send_request(it, 0);
    end
    // both sides of the triangle peak, the last progress step before touchdown, and the first after lift-off
    foreach (edges[i]) begin
      it = random_request();
      it.progress = (i == 0) ? 16'd32767 : (i == 1) ? 16'd32768 :
                    (i == 2) ? 16'd65535 : 16'd1;
      send_request(it, i);
    end
    // wrap of a large yaw angle
    set_regs(16'hFFFF, 15'h7FFF, 10'd1023, 10'd1023, 10'd1023);
    for (int i = 0; i < 4; i++) begin
      it = random_request();
      it.yaw_rate = (i < 2) ? 16'h7FFF : 16'h8000;
      it.progress = (i % 2) ? 16'hFFFF : 16'd0;
      send_request(it, 0);
    end
  endtask

  task automatic test_touchdown();
    swft_pkg::in_item_t it;
    // zero tick period, then zero swing length: always at touchdown
    set_regs(16'd0, 15'd100, 10'd0, 10'd0, 10'd1);
    for (int i = 0; i < 4; i++) send_request(random_request(), 0);
    set_regs(16'd655, 15'd0, 10'd100, 10'd100, 10'd0);
    for (int i = 0; i < 4; i++) send_request(random_request(), 1);
    // short remaining time near the epsilon boundary
    set_regs(16'd1, 15'd246, 10'd100, 10'd100, 10'd1);
    for (int i = 0; i < 4; i++) begin
      it = random_request();
      it.progress = 16'(65536 - 4294 + i - 1);
      send_request(it, 0);
    end
  endtask

  task automatic test_random_phase(int count);
    int stretch;
    for (int i = 0; i < count; i++) begin
      stretch = $urandom_range(0, 99);
      sink_free = stretch < 15;
      send_request(random_request(), pick_gap(stretch < 25));
    end
    sink_free = 0;
  endtask

  task automatic test_random();
    set_regs(swft_pkg::RST_STEP_PERIOD, swft_pkg::RST_LIFT_HEIGHT,
             swft_pkg::RST_PHASE_TICKS, swft_pkg::RST_STANCE_TICKS,
             swft_pkg::RST_SWING_TICKS);
    test_random_phase(80);
    for (int p = 0; p < 5; p++) begin
      set_regs(16'($urandom), 15'($urandom), 10'($urandom), 10'($urandom),
               10'($urandom_range(1, 1023)));
      test_random_phase(70);
    end
    set_regs(16'd1, 15'd1, 10'd1, 10'd1, 10'd1);
    test_random_phase(60);
    set_regs(16'hFFFF, 15'h7FFF, 10'd1023, 10'd1023, 10'd1023);
    test_random_phase(60);
    set_regs(16'd200, 15'd400, 10'd50, 10'd50, 10'd20);
    test_random_phase(80);
  endtask

  initial begin
    errors = 0;
    sink_free = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    cur_period = swft_pkg::RST_STEP_PERIOD;
    cur_lift   = swft_pkg::RST_LIFT_HEIGHT;
    cur_phase  = swft_pkg::RST_PHASE_TICKS;
    cur_stance = swft_pkg::RST_STANCE_TICKS;
    cur_swing  = swft_pkg::RST_SWING_TICKS;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_touchdown();
    test_random();

    drain();
    if (errors == 0) begin
      $display("swing_foot_trajectory_step_tb: clean");
    end else begin
      $display("swing_foot_trajectory_step_tb: errors");
    end
    $finish;
  end
endmodule
